FILE: hdl/swsd_pkg.sv
// Shared constants, codes and control structs for the sample window statistics block.
package swsd_pkg;

  // Default widths of the voltage and counter paths
  localparam int VoltageBitsDef = 16;
  localparam int CountBitsDef   = 16;

  // Fixed field widths
  localparam int TimeBits     = 63;
  localparam int GapBits      = 32;
  localparam int TotalBits    = 48;
  localparam int CfgBits      = 16;
  localparam int CfgIndexBits = 2;
  localparam int AvgFrac      = 16;

  // Register reset values
  localparam logic [CfgBits-1:0] DipThresholdRst  = 16'd1638;
  localparam logic [CfgBits-1:0] DipHysteresisRst = 16'd492;
  localparam logic [CfgBits-1:0] AverageWeightRst = 16'd66;

  // Configuration register indexes
  typedef enum logic [CfgIndexBits-1:0] {
    CfgDipThreshold  = 2'd0,
    CfgDipHysteresis = 2'd1,
    CfgAverageWeight = 2'd2
  } cfg_index_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic stats;
    logic merge;
    logic dip;
    logic div_start;
    logic load;
  } swsd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;
    logic div_done;
  } swsd_status_t;

endpackage

FILE: hdl/swsd_if.sv
// Handshake channel interfaces: samples in, window results out, register writes.
interface swsd_sample_if
  import swsd_pkg::*;
#(
  parameter int VOLTAGE_BITS = VoltageBitsDef
);
  logic                    valid;
  logic                    ready;
  logic [VOLTAGE_BITS-1:0] voltage;
  logic [TimeBits-1:0]     timestamp;
  logic                    window_first;
  logic                    window_last;

  modport source (output valid, voltage, timestamp, window_first, window_last, input ready);
  modport sink   (input valid, voltage, timestamp, window_first, window_last, output ready);
endinterface

interface swsd_result_if
  import swsd_pkg::*;
#(
  parameter int VOLTAGE_BITS = VoltageBitsDef,
  parameter int COUNT_BITS   = CountBitsDef
);
  logic                    valid;
  logic                    ready;
  logic [COUNT_BITS-1:0]   sample_count;
  logic [VOLTAGE_BITS-1:0] min_voltage;
  logic [VOLTAGE_BITS-1:0] max_voltage;
  logic [VOLTAGE_BITS-1:0] average_voltage;
  logic [COUNT_BITS-1:0]   dip_count;
  logic [GapBits-1:0]      min_interval;
  logic [GapBits-1:0]      max_interval;
  logic [GapBits-1:0]      average_interval;
  logic                    interval_valid;

  modport source (output valid, sample_count, min_voltage, max_voltage, average_voltage,
                  dip_count, min_interval, max_interval, average_interval, interval_valid,
                  input ready);
  modport sink   (input valid, sample_count, min_voltage, max_voltage, average_voltage,
                  dip_count, min_interval, max_interval, average_interval, interval_valid,
                  output ready);
endinterface

interface swsd_cfg_if
  import swsd_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CfgIndexBits-1:0] index;
  logic [CfgBits-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/swsd_divider.sv
// Restoring divider, one quotient bit per cycle, for the average interval.
module swsd_divider
  import swsd_pkg::*;
#(
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [TotalBits-1:0]  dividend_i,
  input  logic [COUNT_BITS-1:0] divisor_i,
  output logic                  done_o,
  output logic [TotalBits-1:0]  quotient_o
);

  localparam int StepBits = $clog2(TotalBits + 1);
  localparam logic [StepBits-1:0] Steps = StepBits'(TotalBits);

  logic [StepBits-1:0]   step_q, step_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [TotalBits-1:0]  quo_q, quo_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS-1:0] dvs_q, dvs_d;
  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS:0]   diff;

  // Shift in the next dividend bit and try a subtraction
  always_comb begin
    rem_sh = {rem_q, quo_q[TotalBits-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      step_d = Steps;
      busy_d = 1'b1;
      done_d = 1'b0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = diff[COUNT_BITS-1:0];
        quo_d = {quo_q[TotalBits-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[COUNT_BITS-1:0];
        quo_d = {quo_q[TotalBits-2:0], 1'b0};
      end
      step_d = step_q - StepBits'(1);
      if (step_q == StepBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hdl/swsd_datapath.sv
// Datapath: registers, window statistics, moving average, dip detector and result word.
module swsd_datapath
  import swsd_pkg::*;
#(
  parameter int VOLTAGE_BITS = VoltageBitsDef,
  parameter int COUNT_BITS   = CountBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  swsd_cmd_t               cmd_i,
  output swsd_status_t            status_o,
  // register writes
  input  logic                    cfg_we_i,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgBits-1:0]      cfg_data_i,
  // sample word
  input  logic [VOLTAGE_BITS-1:0] voltage_i,
  input  logic [TimeBits-1:0]     timestamp_i,
  input  logic                    window_first_i,
  input  logic                    window_last_i,
  // result word
  output logic [COUNT_BITS-1:0]   sample_count_o,
  output logic [VOLTAGE_BITS-1:0] min_voltage_o,
  output logic [VOLTAGE_BITS-1:0] max_voltage_o,
  output logic [VOLTAGE_BITS-1:0] average_voltage_o,
  output logic [COUNT_BITS-1:0]   dip_count_o,
  output logic [GapBits-1:0]      min_interval_o,
  output logic [GapBits-1:0]      max_interval_o,
  output logic [GapBits-1:0]      average_interval_o,
  output logic                    interval_valid_o
);

  localparam int AccBits  = VOLTAGE_BITS + AvgFrac;
  localparam int WvBits   = CfgBits + VOLTAGE_BITS;
  localparam int PwBits   = CfgBits + 1;
  localparam int PaccBits = PwBits + AccBits;
  localparam int CmpBits  = ((AccBits > CfgBits + AvgFrac) ? AccBits : CfgBits + AvgFrac) + 2;
  localparam logic [PwBits-1:0]   WeightOne = PwBits'(1) << AvgFrac;
  localparam logic [PaccBits:0]   RoundHalf = (PaccBits + 1)'(1) << (AvgFrac - 1);
  localparam logic [AccBits:0]    OutRound  = (AccBits + 1)'(1) << (AvgFrac - 1);

  // Configuration registers
  logic [CfgBits-1:0] thr_q, hys_q, weight_q;

  // Captured sample
  logic [VOLTAGE_BITS-1:0] v_q;
  logic [TimeBits-1:0]     t_q;
  logic                    first_q, last_q;

  // Carried state
  logic [AccBits-1:0]      acc_q;
  logic                    seeded_q;
  logic                    in_dip_q;
  logic [COUNT_BITS-1:0]   dips_q;
  logic [COUNT_BITS-1:0]   count_q;
  logic [VOLTAGE_BITS-1:0] lowest_q, highest_q;
  logic [TimeBits-1:0]     prev_t_q;
  logic [GapBits-1:0]      shortest_q, longest_q;
  logic [TotalBits-1:0]    total_q;

  // Intermediate registers between steps
  logic [GapBits-1:0]      gap_q;
  logic                    has_gap_q;
  logic [WvBits-1:0]       wv_q;
  logic [PaccBits-1:0]     pacc_q;

  // Step logic
  logic [TimeBits-1:0]     t_diff;
  logic [GapBits-1:0]      gap_sat;
  logic [TotalBits:0]      total_sum;
  logic [PaccBits:0]       pacc_round;
  logic [AccBits-1:0]      acc_blend;
  logic [CmpBits-1:0]      cmp_sample, cmp_level, cmp_leave;
  logic [AccBits:0]        avg_round;
  logic [VOLTAGE_BITS:0]   avg_wide;
  logic [VOLTAGE_BITS-1:0] avg_sat;
  logic [TotalBits-1:0]    quotient;
  logic                    div_done;
  logic [COUNT_BITS-1:0]   divisor;
  logic                    enough;

  // Saturated gap to the previous sample, zero when time steps back
  always_comb begin
    t_diff  = (t_q >= prev_t_q) ? (t_q - prev_t_q) : '0;
    gap_sat = (t_diff[TimeBits-1:GapBits] != '0) ? '1 : t_diff[GapBits-1:0];
  end

  // Saturated interval total and rounded average blend
  always_comb begin
    total_sum  = {1'b0, total_q} + (TotalBits + 1)'(gap_q);
    pacc_round = {1'b0, pacc_q} + RoundHalf;
    acc_blend  = AccBits'(pacc_round[PaccBits:AvgFrac]) + AccBits'(wv_q);
  end

  // Dip comparisons on the sample plus threshold against the average
  always_comb begin
    cmp_sample = (CmpBits'(v_q) << AvgFrac) + (CmpBits'(thr_q) << AvgFrac);
    cmp_level  = CmpBits'(acc_q);
    cmp_leave  = CmpBits'(acc_q) + (CmpBits'(hys_q) << AvgFrac);
  end

  // Rounded, saturated average voltage for the result
  always_comb begin
    avg_round = {1'b0, acc_q} + OutRound;
    avg_wide  = avg_round[AccBits:AvgFrac];
    avg_sat   = avg_wide[VOLTAGE_BITS] ? '1 : avg_wide[VOLTAGE_BITS-1:0];
  end

  assign enough  = (count_q >= COUNT_BITS'(2));
  assign divisor = count_q - COUNT_BITS'(1);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= DipThresholdRst;
      hys_q    <= DipHysteresisRst;
      weight_q <= AverageWeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDipThreshold:  thr_q    <= cfg_data_i;
        CfgDipHysteresis: hys_q    <= cfg_data_i;
        CfgAverageWeight: weight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the sample word and hold the step products
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      v_q     <= voltage_i;
      t_q     <= timestamp_i;
      first_q <= window_first_i;
      last_q  <= window_last_i;
    end
    if (cmd_i.stats) begin
      gap_q  <= gap_sat;
      wv_q   <= WvBits'(weight_q) * WvBits'(v_q);
      pacc_q <= PaccBits'(WeightOne - PwBits'(weight_q)) * PaccBits'(acc_q);
    end
  end

  // Carried state: window statistics, average and dip detector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      seeded_q   <= 1'b0;
      in_dip_q   <= 1'b0;
      dips_q     <= '0;
      count_q    <= '0;
      lowest_q   <= '1;
      highest_q  <= '0;
      prev_t_q   <= '0;
      shortest_q <= '1;
      longest_q  <= '0;
      total_q    <= '0;
      has_gap_q  <= 1'b0;
    end else begin
      // clear on a window start, take the voltage, count the sample
      if (cmd_i.stats) begin
        prev_t_q <= t_q;
        if (first_q) begin
          count_q    <= COUNT_BITS'(1);
          lowest_q   <= v_q;
          highest_q  <= v_q;
          dips_q     <= '0;
          shortest_q <= '1;
          longest_q  <= '0;
          total_q    <= '0;
          has_gap_q  <= 1'b0;
        end else begin
          if (count_q != '1) count_q <= count_q + COUNT_BITS'(1);
          if (v_q < lowest_q) lowest_q <= v_q;
          if (v_q > highest_q) highest_q <= v_q;
          has_gap_q <= (count_q != '0);
        end
      end
      // fold the gap in and advance the average
      if (cmd_i.merge) begin
        if (has_gap_q) begin
          if (gap_q < shortest_q) shortest_q <= gap_q;
          if (gap_q > longest_q) longest_q <= gap_q;
          total_q <= total_sum[TotalBits] ? '1 : total_sum[TotalBits-1:0];
        end
        if (!seeded_q) begin
          acc_q    <= AccBits'(v_q) << AvgFrac;
          seeded_q <= 1'b1;
        end else begin
          acc_q <= acc_blend;
        end
      end
      // enter or leave a dip
      if (cmd_i.dip) begin
        if (!in_dip_q && (cmp_sample < cmp_level)) begin
          in_dip_q <= 1'b1;
          if (dips_q != '1) dips_q <= dips_q + COUNT_BITS'(1);
        end else if (in_dip_q && (cmp_sample > cmp_leave)) begin
          in_dip_q <= 1'b0;
        end
      end
    end
  end

  swsd_divider #(
    .COUNT_BITS (COUNT_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (total_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Result word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_count_o    <= count_q;
      min_voltage_o     <= lowest_q;
      max_voltage_o     <= highest_q;
      average_voltage_o <= avg_sat;
      dip_count_o       <= dips_q;
      min_interval_o    <= shortest_q;
      max_interval_o    <= longest_q;
      interval_valid_o  <= enough;
      if (!enough) begin
        average_interval_o <= '0;
      end else if (quotient[TotalBits-1:GapBits] != '0) begin
        average_interval_o <= '1;
      end else begin
        average_interval_o <= quotient[GapBits-1:0];
      end
    end
  end

  assign status_o.last     = last_q;
  assign status_o.div_done = div_done;

endmodule

FILE: hdl/swsd_ctrl.sv
// Controller: sequences one sample through the datapath and hands off the result word.
module swsd_ctrl
  import swsd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  swsd_status_t status_i,
  output swsd_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_STATS = 6'b000010,
    S_MERGE = 6'b000100,
    S_DIP   = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_STATS;
        end
      end
      S_STATS: begin
        cmd_o.stats = 1'b1;
        state_d     = S_MERGE;
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = S_DIP;
      end
      S_DIP: begin
        cmd_o.dip = 1'b1;
        if (status_i.last) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (status_i.div_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/sample_window_stats_dip_counter.sv
// Top level of the windowed voltage statistics block with moving-average dip counter.
//
//   port      dir  word                                         handshake
//   sample_i  in   voltage, timestamp, window_first/last        valid/ready
//   result_o  out  counts, voltage stats, interval stats, valid valid/ready
//   cfg_i     in   register index and data                      valid/ready, always ready
//
// A sample passes through these steps from one acceptance to the next (capture, statistics and
// products, gap fold and average, dip check). A window's last sample then waits while the
// divider produces its 48 quotient bits, and the result word is loaded once the divider is
// seen to finish and the output register is free.
// Reset restores register defaults and clears average, dip and window state.
// A result waiting in the output register does not hold up the next sample; only the
// load of a following result waits for it to be taken.
module sample_window_stats_dip_counter
  import swsd_pkg::*;
#(
  parameter int VOLTAGE_BITS = VoltageBitsDef,
  parameter int COUNT_BITS   = CountBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swsd_sample_if.sink   sample_i,
  swsd_result_if.source result_o,
  swsd_cfg_if.sink      cfg_i
);

  swsd_cmd_t    cmd;
  swsd_status_t status;

  assign cfg_i.ready = 1'b1;

  swsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  swsd_datapath #(
    .VOLTAGE_BITS (VOLTAGE_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_i.valid),
    .cfg_index_i        (cfg_i.index),
    .cfg_data_i         (cfg_i.data),
    .voltage_i          (sample_i.voltage),
    .timestamp_i        (sample_i.timestamp),
    .window_first_i     (sample_i.window_first),
    .window_last_i      (sample_i.window_last),
    .sample_count_o     (result_o.sample_count),
    .min_voltage_o      (result_o.min_voltage),
    .max_voltage_o      (result_o.max_voltage),
    .average_voltage_o  (result_o.average_voltage),
    .dip_count_o        (result_o.dip_count),
    .min_interval_o     (result_o.min_interval),
    .max_interval_o     (result_o.max_interval),
    .average_interval_o (result_o.average_interval),
    .interval_valid_o   (result_o.interval_valid)
  );

  // A result word never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!result_o.valid || result_o.ready))
    else $error("result word loaded over a pending one");

  // The divider only starts for a window's last sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> status.last)
    else $error("divider started for a sample that closes no window");

  // An accepted sample blocks the input until its steps are done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> !sample_i.ready)
    else $error("sample accepted while the previous one is in progress");

  // The output only turns valid right after a load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(cmd.load))
    else $error("result valid raised without a load");

endmodule
